// File: hw/rtl/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg: shared definitions of the streaming inversion counter
// Widths, defaults and the control bundle handed to every tree cell.
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int DEF_VALUE_BITS = 10;
  localparam int DEF_MAX_LEN    = 4096;

  localparam int TOTAL_W = 23;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam int EPOCH_W = 8;

  typedef struct packed {
    logic               clr;
    logic [EPOCH_W-1:0] epoch;
  } cell_ctl_t;

endpackage

// File: hw/rtl/sic_in_if.sv
// ----------------------------------------------------------------------------
// sic_in_if: input channel of the inversion counter
// Carries one sequence element and its start-of-sequence flag per word.
// ----------------------------------------------------------------------------
interface sic_in_if #(
  parameter int VALUE_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface

// File: hw/rtl/sic_out_if.sv
// ----------------------------------------------------------------------------
// sic_out_if: result channel of the inversion counter
// Carries the running inversion count and the overflow flag per word.
// ----------------------------------------------------------------------------
interface sic_out_if;
  logic        valid;
  logic        ready;
  logic [22:0] inversions;
  logic        overflow;

  modport source (output valid, output inversions, output overflow, input ready);
  modport sink   (input valid, input inversions, input overflow, output ready);
endinterface

// File: hw/rtl/streaming_inversion_counter_core.sv
// ----------------------------------------------------------------------------
// streaming_inversion_counter_core: running inversion count of a value stream
// Each input word carries one element; each produces one result word with
// the number of inversions among the elements of the current sequence.
//
// Words enter on din and leave on dout, both valid/ready channels. A word
// with first set opens a new sequence. The element walks a row of
// VALUE_BITS tree cells, one tree level per cycle, each cell doing a
// read, add and write of its own level memory. The result word is
// presented in the output register, and the next element can be taken
// in the cycle after; a new element is not taken before the last one's
// result word is out, so the level-by-level walk sets the rate.
// After reset a clearing pass runs through every row of all level memories
// before the first word is taken. The same pass runs at the start of every
// 255th sequence, delaying its first word.
// A stalled receiver holds the result word in the output register; one
// further element is accepted and its result waits until dout is free.
// Beyond MAX_LEN elements the count holds, overflow stays set and the walk
// is skipped for such words.
// ----------------------------------------------------------------------------
module streaming_inversion_counter_core #(
  parameter int VALUE_BITS = sic_pkg::DEF_VALUE_BITS,
  parameter int MAX_LEN    = sic_pkg::DEF_MAX_LEN
) (
  input logic  clk,
  input logic  rst,
  sic_in_if.sink    din,
  sic_out_if.source dout
);
  import sic_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int CLR_W = (VALUE_BITS > 1) ? VALUE_BITS - 1 : 1;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LAUNCH = 3'd2;
  localparam logic [2:0] ST_RUN    = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]            state;
  logic [CLR_W-1:0]      clr_cnt;
  logic                  clr_item;
  logic [EPOCH_W-1:0]    epoch;
  logic [TOTAL_W-1:0]    total;
  logic [CNT_W-1:0]      count;
  logic                  ovf;
  logic [VALUE_BITS-1:0] hold_value;
  logic                  out_valid;
  logic [TOTAL_W-1:0]    out_inv;
  logic                  out_ovf;

  logic                  full;
  logic                  launch;
  logic [TOTAL_W:0]      sum_ext;
  logic [TOTAL_W-1:0]    total_sat;
  cell_ctl_t             ctl;

  logic                  ch_valid [VALUE_BITS+1];
  logic [VALUE_BITS-1:0] ch_value [VALUE_BITS+1];
  logic [CNT_W-1:0]      ch_sum   [VALUE_BITS+1];

  assign full     = (count >= CNT_W'(MAX_LEN));
  assign launch   = (state == ST_LAUNCH) && !full;
  assign ctl.clr  = (state == ST_CLEAR);
  assign ctl.epoch = epoch;

  assign ch_valid[0] = launch;
  assign ch_value[0] = hold_value;
  assign ch_sum[0]   = '0;

  genvar g;
  generate
    for (g = 0; g < VALUE_BITS; g++) begin : g_cell
      sic_cell #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W),
        .DEPTH      (g + 1),
        .CLR_W      (CLR_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .clr_row   (clr_cnt),
        .in_valid  (ch_valid[g]),
        .in_value  (ch_value[g]),
        .in_sum    (ch_sum[g]),
        .out_valid (ch_valid[g+1]),
        .out_value (ch_value[g+1]),
        .out_sum   (ch_sum[g+1])
      );
    end
  endgenerate

  assign sum_ext   = {1'b0, total} + (TOTAL_W + 1)'(ch_sum[VALUE_BITS]);
  assign total_sat = sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];

  assign din.ready       = (state == ST_IDLE);
  assign dout.valid      = out_valid;
  assign dout.inversions = out_inv;
  assign dout.overflow   = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      clr_item  <= 1'b0;
      epoch     <= '0;
      total     <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && dout.ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            epoch    <= EPOCH_W'(1);
            clr_item <= 1'b0;
            state    <= clr_item ? ST_LAUNCH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (din.valid) begin
            hold_value <= din.value;
            if (din.first) begin
              total <= '0;
              count <= '0;
              ovf   <= 1'b0;
              if (epoch == '1) begin
                clr_cnt  <= '0;
                clr_item <= 1'b1;
                state    <= ST_CLEAR;
              end else begin
                epoch <= epoch + 1'b1;
                state <= ST_LAUNCH;
              end
            end else begin
              state <= ST_LAUNCH;
            end
          end
        end
        ST_LAUNCH: begin
          if (full) begin
            ovf   <= 1'b1;
            state <= ST_OUT;
          end else begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (ch_valid[VALUE_BITS]) begin
            total <= total_sat;
            count <= count + 1'b1;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || dout.ready) begin
            out_valid <= 1'b1;
            out_inv   <= total;
            out_ovf   <= ovf;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/sic_cell.sv
// ----------------------------------------------------------------------------
// sic_cell: one level of the count tree
// Holds the child counts of every node at one depth, tagged by sequence epoch,
// adds the right sibling's count and increments the node on the element's path.
// ----------------------------------------------------------------------------
module sic_cell #(
  parameter int VALUE_BITS = 10,
  parameter int CNT_W      = 13,
  parameter int DEPTH      = 1,
  parameter int CLR_W      = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sic_pkg::cell_ctl_t    ctl,
  input  logic [CLR_W-1:0]      clr_row,
  input  logic                  in_valid,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [CNT_W-1:0]      in_sum,
  output logic                  out_valid,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [CNT_W-1:0]      out_sum
);
  import sic_pkg::*;

  localparam int ROW_W   = (DEPTH > 1) ? DEPTH - 1 : 1;
  localparam int ROWS    = 1 << ROW_W;
  localparam int BIT_POS = VALUE_BITS - DEPTH;
  localparam int ENTRY_W = EPOCH_W + 2 * CNT_W;

  logic [ENTRY_W-1:0]    mem [ROWS];
  logic [ENTRY_W-1:0]    rd;
  logic                  busy;
  logic [VALUE_BITS-1:0] st_value;
  logic [CNT_W-1:0]      st_sum;
  logic [ROW_W-1:0]      st_row;
  logic [ROW_W-1:0]      row_addr;

  logic                  hit;
  logic                  dir;
  logic [CNT_W-1:0]      left;
  logic [CNT_W-1:0]      right;
  logic [ENTRY_W-1:0]    wr_entry;

  generate
    if (DEPTH > 1) begin : g_addr
      assign row_addr = in_value[VALUE_BITS-1 -: ROW_W];
    end else begin : g_root
      assign row_addr = '0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      rd       <= mem[row_addr];
      st_value <= in_value;
      st_sum   <= in_sum;
      st_row   <= row_addr;
    end
  end

  always_comb begin
    hit   = (rd[ENTRY_W-1 -: EPOCH_W] == ctl.epoch);
    dir   = st_value[BIT_POS];
    right = hit ? rd[2*CNT_W-1 -: CNT_W] : '0;
    left  = hit ? rd[CNT_W-1:0] : '0;
    out_sum   = dir ? st_sum : st_sum + right;
    wr_entry  = {ctl.epoch, right + CNT_W'(dir), left + CNT_W'(!dir)};
    out_valid = busy;
    out_value = st_value;
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      mem[clr_row[ROW_W-1:0]] <= '0;
    end else if (busy) begin
      mem[st_row] <= wr_entry;
    end
  end

endmodule

// File: test/sic_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sic_result_checker: result checker of the streaming inversion counter
// Watches both channels of the block. Every accepted input word is run
// through a count tree of its own to give the expected running inversion
// count and overflow flag. Every accepted result word is compared with the
// oldest expected one. The number of failures and of results still owed
// are handed to the top level.
// ----------------------------------------------------------------------------
module sic_result_checker #(
  parameter int VALUE_BITS = sic_pkg::DEF_VALUE_BITS,
  parameter int MAX_LEN    = sic_pkg::DEF_MAX_LEN
) (
  input  logic clk,
  input  logic rst,
  sic_in_if    in_ch,
  sic_out_if   out_ch,
  output int   fails,
  output int   outstanding
);
  import sic_pkg::*;

  localparam int LEAVES = 1 << VALUE_BITS;

  typedef struct packed {
    logic [TOTAL_W-1:0] inversions;
    logic               overflow;
  } result_t;

  int unsigned        tree_cnt [2*LEAVES];
  logic [TOTAL_W-1:0] seq_total;
  int unsigned        seq_len;
  logic               seq_overflow;
  result_t            pending_results [$];

  function automatic void clear_sequence();
    foreach (tree_cnt[k]) tree_cnt[k] = 0;
    seq_total    = '0;
    seq_len      = 0;
    seq_overflow = 1'b0;
  endfunction

  function automatic result_t predict_word(input logic [VALUE_BITS-1:0] v, input logic f);
    int unsigned     node;
    int unsigned     greater;
    int              lvl;
    longint unsigned sum;
    result_t         r;
    if (f) begin
      clear_sequence();
    end
    if (seq_len >= MAX_LEN) begin
      seq_overflow = 1'b1;
    end else begin
      node    = 1;
      greater = 0;
      for (lvl = VALUE_BITS - 1; lvl >= 0; lvl--) begin
        if (!v[lvl]) begin
          greater += tree_cnt[2*node + 1];
        end
        node = 2*node + v[lvl];
      end
      sum = longint'(seq_total) + longint'(greater);
      if (sum > longint'(TOTAL_MAX)) begin
        sum = longint'(TOTAL_MAX);
      end
      seq_total = sum[TOTAL_W-1:0];
      node = LEAVES + v;
      while (node > 0) begin
        tree_cnt[node] += 1;
        node = node >> 1;
      end
      seq_len += 1;
    end
    r.inversions = seq_total;
    r.overflow   = seq_overflow;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      errs;
    errs = 0;
    if (rst) begin
      clear_sequence();
      pending_results.delete();
      fails       <= 0;
      outstanding <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with no element waiting: inversions %0d, overflow %0d",
                 out_ch.inversions, out_ch.overflow);
          errs++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.inversions !== want.inversions) begin
            $error("inversions: expected %0d, actual %0d", want.inversions,
                   out_ch.inversions);
            errs++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, out_ch.overflow);
            errs++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(predict_word(in_ch.value, in_ch.first));
      end
      fails       <= fails + errs;
      outstanding <= pending_results.size();
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression of streaming_inversion_counter_core
// Sends a short directed run of edge values, then random sequences of
// several shapes with one long, mostly falling sequence among them, with
// random idle bursts on both channels except in the closing stretch. The
// checker beside the block predicts and compares; this module gives the
// verdict once every result word has come back.
// ----------------------------------------------------------------------------
module tb;
  import sic_pkg::*;

  localparam int VALUE_BITS     = DEF_VALUE_BITS;
  localparam int MAX_LEN        = DEF_MAX_LEN;
  localparam int LEAVES         = 1 << VALUE_BITS;
  localparam int RANDOM_WORDS   = 980;
  localparam int CALM_TAIL      = 120;
  localparam int LONG_LEN       = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 3 * (VALUE_BITS + 4);

  typedef enum int {PAT_SPREAD, PAT_NARROW, PAT_FALLING, PAT_RISING, PAT_EDGES} pattern_e;

  logic clk;
  logic rst;
  logic calm;
  int   gap_odds;
  int   fail_count;
  int   outstanding;
  int   idle_cycles;

  sic_in_if #(.VALUE_BITS(VALUE_BITS)) din_ch ();
  sic_out_if                           dout_ch ();

  streaming_inversion_counter_core #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_LEN   (MAX_LEN)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .din (din_ch),
    .dout(dout_ch)
  );

  sic_result_checker #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_LEN   (MAX_LEN)
  ) result_chk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (din_ch),
    .out_ch     (dout_ch),
    .fails      (fail_count),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("streaming_inversion_counter_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    dout_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        dout_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      dout_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(40, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic f);
    din_ch.valid <= 1'b1;
    din_ch.value <= v;
    din_ch.first <= f;
    @(posedge clk);
    while (!din_ch.ready) @(posedge clk);
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      din_ch.valid <= 1'b0;
      din_ch.value <= VALUE_BITS'($urandom);
      din_ch.first <= 1'($urandom);
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(input pattern_e p, input int idx,
                                                       input int base, input int step);
    int v;
    case (p)
      PAT_SPREAD:  v = $urandom_range(0, LEAVES - 1);
      PAT_NARROW:  v = base + $urandom_range(0, 3);
      PAT_FALLING: v = base - idx * step + $urandom_range(0, 1);
      PAT_RISING:  v = base + idx * step;
      default:     v = ($urandom_range(0, 1) != 0) ? LEAVES - 1 - $urandom_range(0, 1)
                                                   : $urandom_range(0, 1);
    endcase
    return v[VALUE_BITS-1:0];
  endfunction

  initial begin
    int                    dir_values [] = '{0, 1023, 0, 1023, 512, 511, 1, 0, 0, 1023,
                                             0, 1, 2, 1023,
                                             1023, 767, 511, 255, 0,
                                             5, 5, 5, 5};
    bit                    dir_first  [] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                             1, 0, 0, 0,
                                             1, 0, 0, 0, 0,
                                             1, 1, 0, 0};
    int                    sent;
    int                    len;
    int                    base;
    int                    step;
    int                    i;
    bit                    fresh;
    bit                    long_done;
    pattern_e              pat;
    logic [VALUE_BITS-1:0] v;

    rst          = 1'b1;
    calm         = 1'b0;
    gap_odds     = 4;
    din_ch.valid = 1'b0;
    din_ch.value = '0;
    din_ch.first = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_values[k]) begin
      send_word(dir_values[k][VALUE_BITS-1:0], dir_first[k]);
    end

    sent      = 0;
    long_done = 1'b0;
    while (sent < RANDOM_WORDS) begin
      if (!long_done && sent >= RANDOM_WORDS / 2) begin
        long_done = 1'b1;
        gap_odds  = 6;
        for (i = 0; i < LONG_LEN; i++) begin
          if (i % 8 == 7) begin
            v = VALUE_BITS'($urandom_range(0, LEAVES - 1));
          end else begin
            v = VALUE_BITS'(LEAVES - 1 - (i * LEAVES) / LONG_LEN);
          end
          send_word(v, i == 0);
        end
      end
      pat      = pattern_e'($urandom_range(0, 4));
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      base     = $urandom_range(0, LEAVES - 1);
      step     = $urandom_range(0, 5);
      fresh    = ($urandom_range(0, 7) != 0);
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
      for (i = 0; i < len && sent < RANDOM_WORDS; i++) begin
        calm <= (RANDOM_WORDS - sent) <= CALM_TAIL;
        send_word(pick_value(pat, i, base, step), fresh && i == 0);
        sent++;
      end
    end

    din_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("streaming_inversion_counter_core regression: pass");
    end else begin
      $display("streaming_inversion_counter_core regression: fail");
    end
    $finish;
  end

endmodule
